/* hdl/okm_pkg.sv */
// okm_pkg: shared constants, codes and types of the online k-means engine
// used by every module under hdl but okm_ram; depends on nothing

package okm_pkg;

    // fixed field widths and storage sizes
    localparam int COORD_W      = 32;
    localparam int MAX_CLUSTERS = 16;
    localparam int MAX_DIMS     = 16;
    localparam int CL_W         = 4;
    localparam int DIM_W        = 4;
    localparam int ADDR_W       = CL_W + DIM_W;
    localparam int BANK_DEPTH   = MAX_CLUSTERS * MAX_DIMS;
    localparam int REG_W        = 5;
    localparam int TOL_W        = 32;

    // arithmetic widths
    localparam int CNT_W   = 63 - COORD_W;        // saturating assignment count
    localparam int PROD_W  = 2 * COORD_W;         // centre times count, squared difference
    localparam int QUO_W   = COORD_W + 1;         // running mean quotient magnitude
    localparam int ACC_W   = PROD_W + DIM_W;      // summed squared distance
    localparam int ROOT_W  = ACC_W / 2;           // integer square root
    localparam int SUM_W   = ROOT_W + CL_W;       // summed centre movement
    localparam int STEP_W  = 6;                   // step counters of the iterative units

    // bus widths
    localparam int KIND_W     = 2;
    localparam int MODE_W     = 2;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 40;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    typedef enum logic [MODE_W-1:0] {
        MODE_SEED  = 2'd0,
        MODE_POINT = 2'd1,
        MODE_PASS  = 2'd2,
        MODE_READ  = 2'd3
    } t_mode;

    typedef enum logic [KIND_W-1:0] {
        KIND_ASSIGN = 2'd0,
        KIND_STATUS = 2'd1,
        KIND_READ   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        REG_NUM_CLUSTERS = 2'd0,
        REG_NUM_DIMS     = 2'd1,
        REG_TOLERANCE    = 2'd2
    } t_reg_idx;

    // control shared by all cells of the point ring
    typedef struct packed {
        logic               load;
        logic [DIM_W-1:0]   idx;
        logic [COORD_W-1:0] val;
        logic               rot;
        logic [DIM_W-1:0]   last;
    } t_ring_ctl;

endpackage

/* hdl/okm_ram.sv */
// okm_ram: generic single write port, single read port memory
// registered read data; no dependencies

module okm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/okm_cell.sv */
// okm_cell: one cell of the point ring, holds one buffered coordinate
// depends on okm_pkg (t_ring_ctl, widths)

module okm_cell (
    input  logic                        i_clk,
    input  okm_pkg::t_ring_ctl          i_ctl,
    input  logic [okm_pkg::DIM_W-1:0]   i_pos,
    input  logic [okm_pkg::COORD_W-1:0] i_next,
    input  logic [okm_pkg::COORD_W-1:0] i_head,
    output logic [okm_pkg::COORD_W-1:0] o_val
);

    logic [okm_pkg::COORD_W-1:0] r_val;
    logic [okm_pkg::COORD_W-1:0] n_val;

    // ring wraps at the last coordinate in use, cells beyond it hold
    always_comb begin
        n_val = r_val;
        if (i_ctl.load && (i_ctl.idx == i_pos)) begin
            n_val = i_ctl.val;
        end else if (i_ctl.rot && (i_pos <= i_ctl.last)) begin
            n_val = (i_pos == i_ctl.last) ? i_head : i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;

endmodule

/* hdl/okm_div.sv */
// okm_div: iterative restoring divider, one quotient bit per cycle
// depends on okm_pkg (widths); quotient must fit QUO_W bits

module okm_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [okm_pkg::PROD_W-1:0]  i_num,
    input  logic [okm_pkg::COORD_W-1:0] i_den,
    output logic                        o_done,
    output logic [okm_pkg::QUO_W-1:0]   o_quo
);

    logic                        r_busy;
    logic                        r_done;
    logic [okm_pkg::STEP_W-1:0]  r_cnt;
    logic [okm_pkg::COORD_W-1:0] r_rem;
    logic [okm_pkg::COORD_W-1:0] r_den;
    logic [okm_pkg::QUO_W-1:0]   r_q;

    logic [okm_pkg::COORD_W:0]   trial;
    logic [okm_pkg::COORD_W:0]   diff;
    logic                        ge;

    always_comb begin
        trial = {r_rem, r_q[okm_pkg::QUO_W-1]};
        diff  = trial - {1'b0, r_den};
        ge    = (trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == okm_pkg::STEP_W'(okm_pkg::QUO_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // high numerator bits start as the partial remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= okm_pkg::COORD_W'(i_num[okm_pkg::PROD_W-1:okm_pkg::QUO_W]);
            r_q   <= i_num[okm_pkg::QUO_W-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? diff[okm_pkg::COORD_W-1:0] : trial[okm_pkg::COORD_W-1:0];
            r_q   <= {r_q[okm_pkg::QUO_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

/* hdl/okm_sqrt.sv */
// okm_sqrt: iterative integer square root, one root bit per cycle
// depends on okm_pkg (widths)

module okm_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [okm_pkg::ACC_W-1:0]   i_rad,
    output logic                        o_done,
    output logic [okm_pkg::ROOT_W-1:0]  o_root
);

    logic                        r_busy;
    logic                        r_done;
    logic [okm_pkg::STEP_W-1:0]  r_cnt;
    logic [okm_pkg::ACC_W-1:0]   r_rad;
    logic [okm_pkg::ROOT_W:0]    r_rem;
    logic [okm_pkg::ROOT_W-1:0]  r_root;

    logic [okm_pkg::ROOT_W+2:0]  cur;
    logic [okm_pkg::ROOT_W+2:0]  trial;
    logic [okm_pkg::ROOT_W+2:0]  diff;
    logic                        ge;

    always_comb begin
        cur   = {r_rem, r_rad[okm_pkg::ACC_W-1 -: 2]};
        trial = {1'b0, r_root, 2'b01};
        diff  = cur - trial;
        ge    = (cur >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == okm_pkg::STEP_W'(okm_pkg::ROOT_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[okm_pkg::ACC_W-3:0], 2'b00};
            r_rem  <= ge ? diff[okm_pkg::ROOT_W:0] : cur[okm_pkg::ROOT_W:0];
            r_root <= {r_root[okm_pkg::ROOT_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

/* hdl/online_kmeans_assign_update.sv */
// online_kmeans_assign_update: top level of the online k-means engine
// depends on okm_pkg, okm_ram, okm_cell, okm_div, okm_sqrt
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------------------
//  s       | in        | i_s_tvalid / o_s_tready | tuser mode, tdata index and coordinate
//  m       | out       | o_m_tvalid / i_m_tready | tuser result kind, tdata assign/status/value
//  apb     | in        | psel, penable, pready   | num_clusters, num_dims, tolerance
//
// steps: seed and non-final point coordinates are taken in the idle state, a read
// passes through the read state to the output state; a final point coordinate
// runs the distance scan through the point ring, then the centre update per
// coordinate through the one-bit-per-cycle divider; an end of pass scans each
// centre in turn and runs it through the one-bit-per-cycle square root
// reset is synchronous and active low; centre banks hold no reset value
// a result waits in the output register while the next transaction is taken;
// only a finished item that finds the output register still full stalls

module online_kmeans_assign_update (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // [3:0] cluster_index, [7:4] coord_index, [39:8] coord_value
    input  logic [okm_pkg::S_TDATA_W-1:0]     i_s_tdata,
    // [1:0] mode
    input  logic [okm_pkg::MODE_W-1:0]        i_s_tuser,
    // output stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [3:0] assigned_cluster, [4] still_moving, [36:5] center_value, [39:37] zero
    output logic [okm_pkg::M_TDATA_W-1:0]     o_m_tdata,
    // [1:0] result_kind
    output logic [okm_pkg::KIND_W-1:0]        o_m_tuser,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [okm_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [okm_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [okm_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    typedef enum logic [10:0] {
        ST_IDLE      = 11'b000_0000_0001,
        ST_READ      = 11'b000_0000_0010,
        ST_SCAN      = 11'b000_0000_0100,
        ST_UPD_RD    = 11'b000_0000_1000,
        ST_UPD_MUL   = 11'b000_0001_0000,
        ST_UPD_ADD   = 11'b000_0010_0000,
        ST_UPD_DIVS  = 11'b000_0100_0000,
        ST_UPD_DIV   = 11'b000_1000_0000,
        ST_PASS_SCAN = 11'b001_0000_0000,
        ST_PASS_SQRT = 11'b010_0000_0000,
        ST_OUT       = 11'b100_0000_0000
    } t_state;

    localparam int CW = okm_pkg::COORD_W;

    // state and configuration
    t_state                        r_state, n_state;
    logic                          r_active;        // 0: bank a holds the current centres
    logic [okm_pkg::REG_W-1:0]     r_num_clusters;
    logic [okm_pkg::REG_W-1:0]     r_num_dims;
    logic [okm_pkg::TOL_W-1:0]     r_tolerance;
    logic [okm_pkg::CNT_W-1:0]     r_count [okm_pkg::MAX_CLUSTERS];

    // read issue and distance pipeline
    logic                          r_issuing;
    logic                          r_pass;
    logic [okm_pkg::CL_W-1:0]      r_ic;
    logic [okm_pkg::DIM_W-1:0]     r_id;
    logic                          r_v1, r_v2, r_v3;
    logic [okm_pkg::CL_W-1:0]      r_c1, r_c2, r_c3;
    logic                          r_first1, r_first2, r_first3;
    logic                          r_last1, r_last2, r_last3;
    logic [CW-1:0]                 r_mag;
    logic [okm_pkg::PROD_W-1:0]    r_sq;
    logic [okm_pkg::ACC_W-1:0]     r_acc;
    logic [okm_pkg::CL_W-1:0]      r_best;
    logic [okm_pkg::ACC_W-1:0]     r_best_d;
    logic [okm_pkg::SUM_W-1:0]     r_sum;

    // centre update
    logic signed [okm_pkg::PROD_W-1:0] r_prod;
    logic [okm_pkg::PROD_W-1:0]    r_num;
    logic                          r_neg;

    // pending result and output register
    okm_pkg::t_kind                r_res_kind;
    logic [okm_pkg::CL_W-1:0]      r_res_assigned;
    logic                          r_res_still;
    logic [CW-1:0]                 r_res_value;
    logic                          r_out_valid;
    okm_pkg::t_kind                r_out_kind;
    logic [okm_pkg::CL_W-1:0]      r_out_assigned;
    logic                          r_out_still;
    logic [CW-1:0]                 r_out_value;

    // input transaction decode
    logic                          accept;
    okm_pkg::t_mode                in_mode;
    logic [okm_pkg::CL_W-1:0]      in_ci;
    logic [okm_pkg::DIM_W-1:0]     in_di;
    logic [CW-1:0]                 in_val;

    // effective register values
    logic [okm_pkg::REG_W-1:0]     k_eff, nd_eff;
    logic [okm_pkg::CL_W-1:0]      k_last;
    logic [okm_pkg::DIM_W-1:0]     nd_last;

    // memories
    logic [okm_pkg::ADDR_W-1:0]    raddr, waddr;
    logic [CW-1:0]                 wdata;
    logic                          we_a, we_b;
    logic [CW-1:0]                 dout_a, dout_b, act_dout, oth_dout;

    // point ring
    okm_pkg::t_ring_ctl            ring_ctl;
    logic [CW-1:0]                 ring_val [okm_pkg::MAX_DIMS];
    logic [CW-1:0]                 ring_head;

    // datapath
    logic [CW-1:0]                 op_p, op_q;
    logic [CW:0]                   dp;
    logic [CW:0]                   dp_neg;
    logic [CW-1:0]                 mag;
    logic [okm_pkg::ACC_W-1:0]     acc_sum;
    logic                          scan_end;
    logic [okm_pkg::CNT_W-1:0]     w;
    logic [CW-1:0]                 den;
    logic [okm_pkg::PROD_W-1:0]    num_mag;
    logic                          div_start, div_done;
    logic [okm_pkg::QUO_W-1:0]     div_quo, neg_quo;
    logic [CW-1:0]                 upd_res;
    logic                          upd_wr, upd_rot;
    logic                          sqrt_start, sqrt_done;
    logic [okm_pkg::ROOT_W-1:0]    sqrt_root;
    logic [okm_pkg::SUM_W-1:0]     sum_new;
    logic                          out_load;

    // configuration access
    logic                          cfg_wr;
    okm_pkg::t_reg_idx             cfg_idx;

    assign accept     = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == ST_IDLE);
    assign in_mode    = okm_pkg::t_mode'(i_s_tuser);
    assign in_ci      = i_s_tdata[3:0];
    assign in_di      = i_s_tdata[7:4];
    assign in_val     = i_s_tdata[8 +: CW];

    // zero acts as one, anything above the maximum as the maximum
    always_comb begin
        if (r_num_clusters == '0) begin
            k_eff = okm_pkg::REG_W'(1);
        end else if (r_num_clusters > okm_pkg::REG_W'(okm_pkg::MAX_CLUSTERS)) begin
            k_eff = okm_pkg::REG_W'(okm_pkg::MAX_CLUSTERS);
        end else begin
            k_eff = r_num_clusters;
        end
        if (r_num_dims == '0) begin
            nd_eff = okm_pkg::REG_W'(1);
        end else if (r_num_dims > okm_pkg::REG_W'(okm_pkg::MAX_DIMS)) begin
            nd_eff = okm_pkg::REG_W'(okm_pkg::MAX_DIMS);
        end else begin
            nd_eff = r_num_dims;
        end
    end

    assign k_last  = okm_pkg::CL_W'(k_eff - 1'b1);
    assign nd_last = okm_pkg::DIM_W'(nd_eff - 1'b1);

    // ---------------------------------------------------------------- centre banks
    always_comb begin
        case (r_state)
            ST_IDLE:                raddr = {in_ci, in_di};
            ST_SCAN, ST_PASS_SCAN:  raddr = {r_ic, r_id};
            default:                raddr = {r_best, r_id};
        endcase
    end

    // seed writes both banks, an update writes the bank not in use
    always_comb begin
        if (r_state == ST_IDLE) begin
            waddr = {in_ci, in_di};
            wdata = in_val;
            we_a  = accept && (in_mode == okm_pkg::MODE_SEED);
            we_b  = we_a;
        end else begin
            waddr = {r_best, r_id};
            wdata = upd_res;
            we_a  = upd_wr && r_active;
            we_b  = upd_wr && !r_active;
        end
    end

    okm_ram #(.WIDTH(CW), .DEPTH(okm_pkg::BANK_DEPTH)) u_bank_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (dout_a)
    );

    okm_ram #(.WIDTH(CW), .DEPTH(okm_pkg::BANK_DEPTH)) u_bank_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (dout_b)
    );

    assign act_dout = r_active ? dout_b : dout_a;
    assign oth_dout = r_active ? dout_a : dout_b;

    // ---------------------------------------------------------------- point ring
    // the ring turns once per coordinate used, so after every whole sweep the
    // first coordinate is back at the head
    always_comb begin
        ring_ctl.load = accept && (in_mode == okm_pkg::MODE_POINT);
        ring_ctl.idx  = in_di;
        ring_ctl.val  = in_val;
        ring_ctl.rot  = (r_v1 && !r_pass) || upd_rot;
        ring_ctl.last = nd_last;
    end

    for (genvar g = 0; g < okm_pkg::MAX_DIMS; g++) begin : g_ring
        okm_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (ring_ctl),
            .i_pos  (okm_pkg::DIM_W'(g)),
            .i_next (ring_val[(g + 1) % okm_pkg::MAX_DIMS]),
            .i_head (ring_val[0]),
            .o_val  (ring_val[g])
        );
    end

    assign ring_head = ring_val[0];

    // ---------------------------------------------------------------- distance pipeline
    // stage 1 difference magnitude, stage 2 square, stage 3 accumulate
    assign op_p   = r_pass ? dout_a : ring_head;
    assign op_q   = r_pass ? dout_b : act_dout;
    assign dp     = {op_p[CW-1], op_p} - {op_q[CW-1], op_q};
    assign dp_neg = ~dp + 1'b1;
    assign mag    = dp[CW] ? dp_neg[CW-1:0] : dp[CW-1:0];

    assign acc_sum  = (r_first3 ? '0 : r_acc) + okm_pkg::ACC_W'(r_sq);
    assign scan_end = r_v3 && r_last3 && (r_c3 == k_last);

    // ---------------------------------------------------------------- running mean
    assign w       = r_count[r_best];
    assign den     = CW'({1'b0, w}) + 1'b1;
    assign num_mag = r_num[okm_pkg::PROD_W-1] ? (~r_num + 1'b1) : r_num;

    okm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num_mag),
        .i_den   (den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // quotient of magnitudes with the sign put back truncates toward zero
    assign neg_quo = ~div_quo + 1'b1;
    assign upd_res = r_neg ? neg_quo[CW-1:0] : div_quo[CW-1:0];

    // ---------------------------------------------------------------- centre movement
    okm_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_rad   (acc_sum),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    assign sum_new = r_sum + okm_pkg::SUM_W'(sqrt_root);

    // ---------------------------------------------------------------- sequencer
    assign out_load = (r_state == ST_OUT) && (!r_out_valid || i_m_tready);

    always_comb begin
        n_state    = r_state;
        div_start  = 1'b0;
        sqrt_start = 1'b0;
        upd_wr     = 1'b0;
        upd_rot    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (in_mode)
                        okm_pkg::MODE_POINT: begin
                            if (in_di == nd_last) begin
                                n_state = ST_SCAN;
                            end
                        end
                        okm_pkg::MODE_PASS:  n_state = ST_PASS_SCAN;
                        okm_pkg::MODE_READ:  n_state = ST_READ;
                        default:             n_state = ST_IDLE;
                    endcase
                end
            end
            ST_READ:     n_state = ST_OUT;
            ST_SCAN: begin
                if (scan_end) begin
                    n_state = ST_UPD_RD;
                end
            end
            ST_UPD_RD:   n_state = ST_UPD_MUL;
            ST_UPD_MUL:  n_state = ST_UPD_ADD;
            ST_UPD_ADD:  n_state = ST_UPD_DIVS;
            ST_UPD_DIVS: begin
                div_start = 1'b1;
                n_state   = ST_UPD_DIV;
            end
            ST_UPD_DIV: begin
                if (div_done) begin
                    upd_wr  = 1'b1;
                    upd_rot = 1'b1;
                    n_state = (r_id == nd_last) ? ST_OUT : ST_UPD_RD;
                end
            end
            ST_PASS_SCAN: begin
                if (r_v3 && r_last3) begin
                    sqrt_start = 1'b1;
                    n_state    = ST_PASS_SQRT;
                end
            end
            ST_PASS_SQRT: begin
                if (sqrt_done) begin
                    n_state = (r_ic == k_last) ? ST_OUT : ST_PASS_SCAN;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_active       <= 1'b0;
            r_num_clusters <= okm_pkg::REG_W'(8);
            r_num_dims     <= okm_pkg::REG_W'(4);
            r_tolerance    <= okm_pkg::TOL_W'(655);
            r_issuing      <= 1'b0;
            r_pass         <= 1'b0;
            r_ic           <= '0;
            r_id           <= '0;
            r_v1           <= 1'b0;
            r_v2           <= 1'b0;
            r_v3           <= 1'b0;
            r_out_valid    <= 1'b0;
            for (int i = 0; i < okm_pkg::MAX_CLUSTERS; i++) begin
                r_count[i] <= '0;
            end
        end else begin
            r_state <= n_state;

            if (cfg_wr) begin
                case (cfg_idx)
                    okm_pkg::REG_NUM_CLUSTERS: r_num_clusters <= pwdata[okm_pkg::REG_W-1:0];
                    okm_pkg::REG_NUM_DIMS:     r_num_dims     <= pwdata[okm_pkg::REG_W-1:0];
                    okm_pkg::REG_TOLERANCE:    r_tolerance    <= pwdata[okm_pkg::TOL_W-1:0];
                    default: ;
                endcase
            end

            // read issue: point scan runs over all centres, a pass over one at a time
            r_v1 <= r_issuing;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (r_issuing) begin
                if (r_id == nd_last) begin
                    r_id <= '0;
                    if (r_pass || (r_ic == k_last)) begin
                        r_issuing <= 1'b0;
                    end else begin
                        r_ic <= r_ic + 1'b1;
                    end
                end else begin
                    r_id <= r_id + 1'b1;
                end
            end

            case (r_state)
                ST_IDLE: begin
                    if (accept && (((in_mode == okm_pkg::MODE_POINT) && (in_di == nd_last))
                                   || (in_mode == okm_pkg::MODE_PASS))) begin
                        r_ic      <= '0;
                        r_id      <= '0;
                        r_issuing <= 1'b1;
                        r_pass    <= (in_mode == okm_pkg::MODE_PASS);
                    end
                end
                ST_UPD_DIV: begin
                    if (div_done) begin
                        if (r_id == nd_last) begin
                            r_id <= '0;
                            if (r_count[r_best] != {okm_pkg::CNT_W{1'b1}}) begin
                                r_count[r_best] <= r_count[r_best] + 1'b1;
                            end
                        end else begin
                            r_id <= r_id + 1'b1;
                        end
                    end
                end
                ST_PASS_SQRT: begin
                    if (sqrt_done) begin
                        if (r_ic == k_last) begin
                            r_active <= ~r_active;
                            for (int i = 0; i < okm_pkg::MAX_CLUSTERS; i++) begin
                                r_count[i] <= '0;
                            end
                        end else begin
                            r_ic      <= r_ic + 1'b1;
                            r_id      <= '0;
                            r_issuing <= 1'b1;
                        end
                    end
                end
                default: ;
            endcase

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_issuing) begin
            r_c1     <= r_ic;
            r_first1 <= (r_id == '0);
            r_last1  <= (r_id == nd_last);
        end
        if (r_v1) begin
            r_mag    <= mag;
            r_c2     <= r_c1;
            r_first2 <= r_first1;
            r_last2  <= r_last1;
        end
        if (r_v2) begin
            r_sq     <= r_mag * r_mag;
            r_c3     <= r_c2;
            r_first3 <= r_first2;
            r_last3  <= r_last2;
        end
        // lowest index wins ties, so only a strictly smaller distance replaces
        if (r_v3) begin
            r_acc <= acc_sum;
            if (r_last3 && !r_pass && ((r_c3 == '0) || (acc_sum < r_best_d))) begin
                r_best   <= r_c3;
                r_best_d <= acc_sum;
            end
        end

        case (r_state)
            ST_IDLE: begin
                if (accept && (in_mode == okm_pkg::MODE_PASS)) begin
                    r_sum <= '0;
                end
            end
            ST_READ: begin
                r_res_kind     <= okm_pkg::KIND_READ;
                r_res_assigned <= '0;
                r_res_still    <= 1'b0;
                r_res_value    <= act_dout;
            end
            ST_UPD_MUL: begin
                r_prod <= $signed(oth_dout) * $signed({1'b0, w});
            end
            ST_UPD_ADD: begin
                r_num <= r_prod + {{(okm_pkg::PROD_W - CW){ring_head[CW-1]}}, ring_head};
            end
            ST_UPD_DIVS: begin
                r_neg <= r_num[okm_pkg::PROD_W-1];
            end
            ST_UPD_DIV: begin
                if (div_done && (r_id == nd_last)) begin
                    r_res_kind     <= okm_pkg::KIND_ASSIGN;
                    r_res_assigned <= r_best;
                    r_res_still    <= 1'b0;
                    r_res_value    <= '0;
                end
            end
            ST_PASS_SQRT: begin
                if (sqrt_done) begin
                    r_sum          <= sum_new;
                    r_res_kind     <= okm_pkg::KIND_STATUS;
                    r_res_assigned <= '0;
                    r_res_still    <= (sum_new > okm_pkg::SUM_W'(r_tolerance));
                    r_res_value    <= '0;
                end
            end
            default: ;
        endcase

        if (out_load) begin
            r_out_kind     <= r_res_kind;
            r_out_assigned <= r_res_assigned;
            r_out_still    <= r_res_still;
            r_out_value    <= r_res_value;
        end
    end

    // ---------------------------------------------------------------- ports
    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_kind;
    assign o_m_tdata  = {{(okm_pkg::M_TDATA_W - CW - okm_pkg::CL_W - 1){1'b0}},
                         r_out_value, r_out_still, r_out_assigned};

    // configuration: one register per word, a write completes in the access phase
    assign pready  = 1'b1;
    assign cfg_idx = okm_pkg::t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        case (cfg_idx)
            okm_pkg::REG_NUM_CLUSTERS: prdata = okm_pkg::APB_DATA_W'(r_num_clusters);
            okm_pkg::REG_NUM_DIMS:     prdata = okm_pkg::APB_DATA_W'(r_num_dims);
            okm_pkg::REG_TOLERANCE:    prdata = okm_pkg::APB_DATA_W'(r_tolerance);
            default:                   prdata = '0;
        endcase
    end

endmodule

/* dv/tb.sv */
// tb: self-checking testbench of online_kmeans_assign_update
// depends on okm_pkg and the block under hdl; holds its own centre-bank predictor

module tb;

    // result as it should leave the block
    typedef struct {
        okm_pkg::t_kind kind;
        logic [3:0]     cluster;
        logic           moving;
        logic [31:0]    value;
    } t_expect;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_s_tvalid;
    logic                           o_s_tready;
    logic [okm_pkg::S_TDATA_W-1:0]  i_s_tdata;
    logic [okm_pkg::MODE_W-1:0]     i_s_tuser;
    logic                           o_m_tvalid;
    logic                           i_m_tready;
    logic [okm_pkg::M_TDATA_W-1:0]  o_m_tdata;
    logic [okm_pkg::KIND_W-1:0]     o_m_tuser;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [okm_pkg::APB_ADDR_W-1:0] paddr;
    logic [okm_pkg::APB_DATA_W-1:0] pwdata;
    logic [okm_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    online_kmeans_assign_update DUT (.*);

    // predictor state: both centre banks, counts, point buffer, registers
    logic signed [31:0] centres [2][okm_pkg::MAX_CLUSTERS][okm_pkg::MAX_DIMS];
    logic [31:0]        counts [okm_pkg::MAX_CLUSTERS];
    logic signed [31:0] pbuf [okm_pkg::MAX_DIMS];
    logic               bank_sel;
    logic [4:0]         cfg_clusters;
    logic [4:0]         cfg_dims;
    logic [31:0]        cfg_tol;

    t_expect pending_results[$];
    int      error_count;
    int      hold_cycles;   // long receiver hold-off, counted by the receiver

    // clock and the one reset
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50000000;
        $display("tb: FAIL");
        $finish;
    end

    function automatic int eff_count(logic [4:0] v);
        if (v == 0) return 1;
        return (v > 16) ? 16 : int'(v);
    endfunction

    function automatic logic [127:0] square_diff(logic signed [31:0] a, logic signed [31:0] b);
        longint       d;
        logic [127:0] mag;
        d   = longint'(a) - longint'(b);
        mag = (d < 0) ? 128'(-d) : 128'(d);
        return mag * mag;
    endfunction

    // squared distance from the buffered point to a centre of the active bank
    function automatic logic [127:0] point_distance(int c, int nd);
        logic [127:0] acc;
        acc = '0;
        for (int i = 0; i < nd; i++) acc += square_diff(pbuf[i], centres[bank_sel][c][i]);
        return acc;
    endfunction

    function automatic logic [127:0] bank_distance(int c, int nd);
        logic [127:0] acc;
        acc = '0;
        for (int i = 0; i < nd; i++) acc += square_diff(centres[0][c][i], centres[1][c][i]);
        return acc;
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [127:0] v);
        logic [127:0] r;
        logic [127:0] c;
        r = '0;
        for (int b = 62; b >= 0; b--) begin
            c = r | (128'd1 << b);
            if (c * c <= v) r = c;
        end
        return r[63:0];
    endfunction

    // work out the result of one accepted transaction and queue it
    task automatic predict_item(okm_pkg::t_mode mode, logic [3:0] ci, logic [3:0] di,
                                logic signed [31:0] x);
        int           k;
        int           nd;
        int           best;
        logic [127:0] best_d;
        logic [127:0] d;
        longint       w;
        logic [63:0]  moved;
        t_expect      e;
        k  = eff_count(cfg_clusters);
        nd = eff_count(cfg_dims);
        e  = '{okm_pkg::KIND_ASSIGN, 4'd0, 1'b0, 32'd0};
        case (mode)
            okm_pkg::MODE_SEED: begin
                centres[0][ci][di] = x;
                centres[1][ci][di] = x;
            end
            okm_pkg::MODE_POINT: begin
                pbuf[di] = x;
                if (int'(di) == nd - 1) begin
                    best   = 0;
                    best_d = point_distance(0, nd);
                    for (int i = 1; i < k; i++) begin
                        d = point_distance(i, nd);
                        // strict compare keeps the lowest index on ties
                        if (d < best_d) begin
                            best   = i;
                            best_d = d;
                        end
                    end
                    w = longint'(counts[best]);
                    for (int i = 0; i < nd; i++)
                        centres[~bank_sel][best][i] = 32'(
                            (longint'(centres[~bank_sel][best][i]) * w + longint'(pbuf[i]))
                            / (w + 1));
                    if (counts[best] < 32'h7FFF_FFFF) counts[best]++;
                    e.cluster = 4'(best);
                    pending_results.push_back(e);
                end
            end
            okm_pkg::MODE_PASS: begin
                bank_sel = ~bank_sel;
                moved    = '0;
                for (int i = 0; i < okm_pkg::MAX_CLUSTERS; i++) counts[i] = '0;
                for (int i = 0; i < k; i++) moved += floor_sqrt(bank_distance(i, nd));
                e.kind   = okm_pkg::KIND_STATUS;
                e.moving = (moved > 64'(cfg_tol));
                pending_results.push_back(e);
            end
            default: begin
                e.kind  = okm_pkg::KIND_READ;
                e.value = centres[bank_sel][ci][di];
                pending_results.push_back(e);
            end
        endcase
    endtask

    // receiver: random stalls per transaction plus an optional long hold-off
    initial begin
        int      stall;
        t_expect e;
        stall      = 0;
        i_m_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t unexpected result: expected none, actual kind %0d data %h",
                             $time, o_m_tuser, o_m_tdata);
                    error_count++;
                end else begin
                    e = pending_results.pop_front();
                    if (o_m_tuser != e.kind) begin
                        $display("%0t result_kind: expected %0d, actual %0d",
                                 $time, e.kind, o_m_tuser);
                        error_count++;
                    end
                    if (o_m_tdata[3:0] != e.cluster) begin
                        $display("%0t assigned_cluster: expected %0d, actual %0d",
                                 $time, e.cluster, o_m_tdata[3:0]);
                        error_count++;
                    end
                    if (o_m_tdata[4] != e.moving) begin
                        $display("%0t still_moving: expected %0d, actual %0d",
                                 $time, e.moving, o_m_tdata[4]);
                        error_count++;
                    end
                    if (o_m_tdata[36:5] != e.value) begin
                        $display("%0t center_value: expected %h, actual %h",
                                 $time, e.value, o_m_tdata[36:5]);
                        error_count++;
                    end
                    if (o_m_tdata[39:37] != 3'd0) begin
                        $display("%0t padding: expected 0, actual %h", $time, o_m_tdata[39:37]);
                        error_count++;
                    end
                end
                stall = $urandom_range(0, 3);
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_m_tready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // send one transaction after a random gap; returns at the accepting edge
    task automatic send_item(okm_pkg::t_mode mode, logic [3:0] ci, logic [3:0] di,
                             logic [31:0] x);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= mode;
        i_s_tdata  <= {x, di, ci};
        do @(posedge i_clk); while (!o_s_tready);
        predict_item(mode, ci, di, x);
    endtask

    // sender stops and waits for every expected result, then for the slowest item
    task automatic drain(int settle);
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_reg(okm_pkg::t_reg_idx idx, logic [31:0] val);
        drain(1000);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= okm_pkg::APB_ADDR_W'(4 * idx);
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            okm_pkg::REG_NUM_CLUSTERS: cfg_clusters = val[4:0];
            okm_pkg::REG_NUM_DIMS:     cfg_dims     = val[4:0];
            default:                   cfg_tol      = val;
        endcase
    endtask

    function automatic logic [31:0] rand_coord();
        // mostly near the origin so distances differ, sometimes full range
        if ($urandom_range(0, 4) == 0) return $urandom;
        return 32'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
    endfunction

    // every centre and buffer entry gets written before anything reads it
    task automatic test_prime();
        write_reg(okm_pkg::REG_NUM_DIMS, 32'd16);
        for (int c = 0; c < okm_pkg::MAX_CLUSTERS; c++)
            for (int d = 0; d < okm_pkg::MAX_DIMS; d++)
                send_item(okm_pkg::MODE_SEED, 4'(c), 4'(d), rand_coord());
        for (int d = 0; d < okm_pkg::MAX_DIMS; d++)
            send_item(okm_pkg::MODE_POINT, 4'd0, 4'(d), rand_coord());
    endtask

    // value extremes, ties, stray coordinate, every mode
    task automatic test_directed();
        write_reg(okm_pkg::REG_NUM_CLUSTERS, 32'd4);
        write_reg(okm_pkg::REG_NUM_DIMS, 32'd2);
        write_reg(okm_pkg::REG_TOLERANCE, 32'd0);
        for (int d = 0; d < 2; d++) begin
            send_item(okm_pkg::MODE_SEED, 4'd0, 4'(d), 32'h7FFF_FFFF);
            send_item(okm_pkg::MODE_SEED, 4'd1, 4'(d), 32'h8000_0000);
            send_item(okm_pkg::MODE_SEED, 4'd2, 4'(d), 32'd0);
            send_item(okm_pkg::MODE_SEED, 4'd3, 4'(d), 32'd0);
        end
        // centres 2 and 3 tie, the lower one wins
        send_item(okm_pkg::MODE_POINT, 4'd0, 4'd0, 32'd0);
        send_item(okm_pkg::MODE_POINT, 4'd0, 4'd1, 32'd0);
        send_item(okm_pkg::MODE_POINT, 4'd0, 4'd0, 32'h7FFF_FFFF);
        send_item(okm_pkg::MODE_POINT, 4'd0, 4'd1, 32'h8000_0000);
        // stray coordinate beyond num_dims is stored but completes nothing
        send_item(okm_pkg::MODE_POINT, 4'd0, 4'd15, 32'hFFFF_FFFF);
        send_item(okm_pkg::MODE_POINT, 4'd0, 4'd1, 32'h8000_0000);
        send_item(okm_pkg::MODE_READ, 4'd0, 4'd0, 32'd0);
        send_item(okm_pkg::MODE_PASS, 4'd0, 4'd0, 32'd0);
        send_item(okm_pkg::MODE_READ, 4'd2, 4'd1, 32'd0);
        send_item(okm_pkg::MODE_READ, 4'd15, 4'd15, 32'd0);
        send_item(okm_pkg::MODE_PASS, 4'd0, 4'd0, 32'd0);
    endtask

    // registers at zero and above their maximum, tolerance at its top
    task automatic test_register_limits();
        write_reg(okm_pkg::REG_NUM_CLUSTERS, 32'd0);
        write_reg(okm_pkg::REG_NUM_DIMS, 32'd0);
        write_reg(okm_pkg::REG_TOLERANCE, 32'hFFFF_FFFF);
        repeat (6) send_item(okm_pkg::MODE_POINT, 4'($urandom), 4'd0, rand_coord());
        send_item(okm_pkg::MODE_PASS, 4'd0, 4'd0, 32'd0);
        write_reg(okm_pkg::REG_NUM_CLUSTERS, 32'd31);
        write_reg(okm_pkg::REG_NUM_DIMS, 32'd31);
        repeat (3)
            for (int d = 0; d < okm_pkg::MAX_DIMS; d++)
                send_item(okm_pkg::MODE_POINT, 4'd0, 4'(d), rand_coord());
        send_item(okm_pkg::MODE_PASS, 4'd0, 4'd0, 32'd0);
    endtask

    // receiver holds off while reads keep arriving, so the input stalls
    task automatic test_backpressure();
        write_reg(okm_pkg::REG_NUM_CLUSTERS, 32'd3);
        write_reg(okm_pkg::REG_NUM_DIMS, 32'd2);
        hold_cycles = 400;
        repeat (30) send_item(okm_pkg::MODE_READ, 4'($urandom), 4'($urandom), 32'd0);
        drain(0);
        repeat (10)
            send_item(okm_pkg::MODE_POINT, 4'($urandom), 4'($urandom_range(0, 1)),
                      rand_coord());
    endtask

    // random traffic: mostly whole points, with passes, reads, reseeds and strays
    task automatic test_random(int k, int nd, logic [31:0] tol, int n_items);
        int sent;
        int pick;
        write_reg(okm_pkg::REG_NUM_CLUSTERS, 32'(k));
        write_reg(okm_pkg::REG_NUM_DIMS, 32'(nd));
        write_reg(okm_pkg::REG_TOLERANCE, tol);
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                for (int d = 0; d < eff_count(5'(nd)); d++)
                    send_item(okm_pkg::MODE_POINT, 4'($urandom), 4'(d), rand_coord());
                sent += eff_count(5'(nd));
            end else if (pick < 77) begin
                send_item(okm_pkg::MODE_PASS, 4'($urandom), 4'($urandom), $urandom);
                sent++;
            end else if (pick < 87) begin
                send_item(okm_pkg::MODE_READ, 4'($urandom), 4'($urandom), $urandom);
                sent++;
            end else if (pick < 93) begin
                send_item(okm_pkg::MODE_SEED, 4'($urandom), 4'($urandom), rand_coord());
                sent++;
            end else begin
                send_item(okm_pkg::MODE_POINT, 4'($urandom), 4'($urandom), rand_coord());
                sent++;
            end
        end
    endtask

    initial begin
        error_count  = 0;
        hold_cycles  = 0;
        bank_sel     = 1'b0;
        cfg_clusters = 5'd8;
        cfg_dims     = 5'd4;
        cfg_tol      = 32'd655;
        for (int i = 0; i < okm_pkg::MAX_CLUSTERS; i++) counts[i] = '0;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_prime();
        test_directed();
        test_register_limits();
        test_backpressure();
        test_random(2, 3, 32'd655, 200);
        test_random(1, 1, 32'd0, 150);
        test_random(4, 2, $urandom, 200);
        test_random(16, 16, 32'hFFFF_FFFF, 100);
        test_random(3, 4, 32'd1000, 200);
        test_random($urandom_range(1, 6), $urandom_range(1, 5), $urandom_range(0, 4000), 200);

        drain(1000);
        if (error_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
